// ===== hdl/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// spa_pkg: shared types and constants for the slot pool allocator
// Status codes, sequencer states, the result bundle, fixed field widths and the reset capacity.
// ----------------------------------------------------------------------------
package spa_pkg;

  // Fixed widths of the interface fields.
  localparam int JOB_ID_W = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_ZERO_ID   = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_ACQ,
    S_REL
  } state_t;

  // One result beat.
  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot_index;
    logic [COUNT_W-1:0]   active_count;
  } result_t;

endpackage

// ===== hdl/slot_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// slot_pool_allocator_unit: counting-semaphore slot table
// Acquires the lowest free slot for a job id or releases the lowest slot that
// holds it, and reports status, slot and the active count for every request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and exactly one result
// beat follows on out_valid for a single cycle; the receiver cannot stall, so it
// must take every beat as it appears. An id of zero, or an acquire while the
// count has reached capacity, answers in the cycle after the request is taken.
// An acquire walks the occupied flags one slot a cycle and answers at the
// lowest free slot within capacity. A release reads the id memory through its
// single read port one slot a cycle and answers at the lowest slot that holds
// the id, or with not found once every slot is read. Busy falls on the cycle
// the result beat appears, so the next request may be given then. Reset clears
// the occupied flags at once; there is no clearing pass. The user must write
// the capacity only while the block is idle; the block does not enforce it.
module slot_pool_allocator_unit #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [spa_pkg::JOB_ID_W-1:0]  in_job_id,
  output logic                          out_valid,
  output logic [spa_pkg::STATUS_W-1:0]  out_status,
  output logic [spa_pkg::SLOT_W-1:0]    out_slot_index,
  output logic [spa_pkg::COUNT_W-1:0]   out_active_count,
  input  logic                          cfg_we,
  input  logic [spa_pkg::CAP_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic               wr_en;
  logic               clr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ID_BITS-1:0] wr_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ID_BITS-1:0] rd_data;
  logic [SLOTS-1:0]   occ;
  spa_pkg::result_t   res;

  // Request sequencer.
  spa_ctrl #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .in_job_id (in_job_id),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_valid (out_valid),
    .res       (res),
    .wr_en     (wr_en),
    .clr_en    (clr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .occ       (occ)
  );

  // Slot id memory and occupied flags.
  spa_slot_mem #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .clr_en  (clr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .occ     (occ)
  );

  // Result beat onto the output ports.
  assign out_status       = res.status;
  assign out_slot_index   = res.slot_index;
  assign out_active_count = res.active_count;

endmodule

// ===== hdl/spa_slot_mem.sv =====
// ----------------------------------------------------------------------------
// spa_slot_mem: slot id memory with per-slot occupied flags
// One write port and one registered read port; the occupied flags are cleared
// by reset, so a slot whose flag is low reads as free whatever the memory holds.
// ----------------------------------------------------------------------------
module spa_slot_mem #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16,
  parameter int IDX_W   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic               clr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [ID_BITS-1:0] wr_data,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [ID_BITS-1:0] rd_data,
  output logic [SLOTS-1:0]   occ
);

  logic [ID_BITS-1:0] mem [SLOTS];
  logic [ID_BITS-1:0] rd_data_r;
  logic [SLOTS-1:0]   occ_r;

  // Id storage: write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Occupied flags: set on an acquire write, cleared on a release.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      if (wr_en) begin
        occ_r[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        occ_r[wr_addr] <= 1'b0;
      end
    end
  end

  assign rd_data = rd_data_r;
  assign occ     = occ_r;

endmodule

// ===== hdl/spa_ctrl.sv =====
// ----------------------------------------------------------------------------
// spa_ctrl: request sequencer for the slot pool allocator
// Holds the capacity register and the occupied count, scans the occupied flags
// for an acquire and the id memory for a release, and issues one result beat.
// ----------------------------------------------------------------------------
module spa_ctrl #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16,
  parameter int IDX_W   = 4,
  parameter int CNT_W   = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          in_kind,
  input  logic [spa_pkg::JOB_ID_W-1:0]  in_job_id,
  output logic                          busy,
  input  logic                          cfg_we,
  input  logic [spa_pkg::CAP_W-1:0]     cfg_wdata,
  output logic                          res_valid,
  output spa_pkg::result_t              res,
  output logic                          wr_en,
  output logic                          clr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [ID_BITS-1:0]            wr_data,
  output logic                          rd_en,
  output logic [IDX_W-1:0]              rd_addr,
  input  logic [ID_BITS-1:0]            rd_data,
  input  logic [SLOTS-1:0]              occ
);

  // Comparison width wide enough for both the capacity field and the count.
  localparam int CW = (CNT_W > spa_pkg::CAP_W) ? CNT_W : spa_pkg::CAP_W;

  spa_pkg::state_t           state_r, state_nxt;
  logic [ID_BITS-1:0]        id_r, id_nxt;
  logic [CNT_W-1:0]          scan_r, scan_nxt;
  logic [IDX_W-1:0]          cmp_r, cmp_nxt;
  logic                      pend_r, pend_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [spa_pkg::CAP_W-1:0] cap_r;
  spa_pkg::result_t          res_r, res_nxt;
  logic                      res_vld_r, res_vld_nxt;

  logic [ID_BITS-1:0] id_in;
  logic [CW-1:0]      cap_ext;
  logic [CW-1:0]      cap_eff;
  logic [CW-1:0]      cnt_ext;
  logic [CW-1:0]      scan_ext;
  logic [IDX_W-1:0]   scan_idx;
  logic               hit;

  // The job id is taken at the id width of the table.
  always_comb begin
    id_in = '0;
    for (int b = 0; b < ID_BITS; b++) begin
      if (b < spa_pkg::JOB_ID_W) begin
        id_in[b] = in_job_id[b];
      end
    end
  end

  // Usable capacity is limited to the slots that are built.
  assign cap_ext  = CW'(cap_r);
  assign cap_eff  = (cap_ext > CW'(SLOTS)) ? CW'(SLOTS) : cap_ext;
  assign cnt_ext  = CW'(cnt_r);
  assign scan_ext = CW'(scan_r);
  assign scan_idx = scan_r[IDX_W-1:0];

  // A release hit: the slot read last cycle is occupied and holds the id.
  assign hit = pend_r && occ[cmp_r] && (rd_data == id_r);

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= spa_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= spa_pkg::S_IDLE;
      cnt_r     <= '0;
      res_vld_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      res_vld_r <= res_vld_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // Working registers of the current request and the result beat.
  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    scan_r <= scan_nxt;
    cmp_r  <= cmp_nxt;
    res_r  <= res_nxt;
  end

  // Next state, memory accesses and result.
  always_comb begin
    state_nxt   = state_r;
    id_nxt      = id_r;
    scan_nxt    = scan_r;
    cmp_nxt     = cmp_r;
    pend_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    res_nxt     = res_r;
    res_vld_nxt = 1'b0;
    wr_en       = 1'b0;
    clr_en      = 1'b0;
    wr_addr     = scan_idx;
    wr_data     = id_r;
    rd_en       = 1'b0;
    rd_addr     = scan_idx;

    case (state_r)
      spa_pkg::S_IDLE: begin
        if (start) begin
          id_nxt   = id_in;
          scan_nxt = '0;
          if (id_in == '0) begin
            res_nxt.status       = spa_pkg::ST_ZERO_ID;
            res_nxt.slot_index   = '0;
            res_nxt.active_count = spa_pkg::COUNT_W'(cnt_r);
            res_vld_nxt          = 1'b1;
          end else if (!in_kind) begin
            if (cnt_ext >= cap_eff) begin
              res_nxt.status       = spa_pkg::ST_FULL;
              res_nxt.slot_index   = '0;
              res_nxt.active_count = spa_pkg::COUNT_W'(cnt_r);
              res_vld_nxt          = 1'b1;
            end else begin
              state_nxt = spa_pkg::S_ACQ;
            end
          end else begin
            state_nxt = spa_pkg::S_REL;
          end
        end
      end

      // Walk the occupied flags for the lowest free slot within capacity.
      spa_pkg::S_ACQ: begin
        if (scan_ext >= cap_eff) begin
          res_nxt.status       = spa_pkg::ST_FULL;
          res_nxt.slot_index   = '0;
          res_nxt.active_count = spa_pkg::COUNT_W'(cnt_r);
          res_vld_nxt          = 1'b1;
          state_nxt            = spa_pkg::S_IDLE;
        end else if (!occ[scan_idx]) begin
          wr_en                = 1'b1;
          cnt_nxt              = cnt_r + 1'b1;
          res_nxt.status       = spa_pkg::ST_OK;
          res_nxt.slot_index   = spa_pkg::SLOT_W'(scan_idx);
          res_nxt.active_count = spa_pkg::COUNT_W'(cnt_r + 1'b1);
          res_vld_nxt          = 1'b1;
          state_nxt            = spa_pkg::S_IDLE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      // Read one slot a cycle and compare the slot read the cycle before.
      spa_pkg::S_REL: begin
        if (hit) begin
          clr_en               = 1'b1;
          wr_addr              = cmp_r;
          cnt_nxt              = cnt_r - 1'b1;
          res_nxt.status       = spa_pkg::ST_OK;
          res_nxt.slot_index   = spa_pkg::SLOT_W'(cmp_r);
          res_nxt.active_count = spa_pkg::COUNT_W'(cnt_r - 1'b1);
          res_vld_nxt          = 1'b1;
          state_nxt            = spa_pkg::S_IDLE;
        end else if (scan_ext == CW'(SLOTS)) begin
          res_nxt.status       = spa_pkg::ST_NOT_FOUND;
          res_nxt.slot_index   = '0;
          res_nxt.active_count = spa_pkg::COUNT_W'(cnt_r);
          res_vld_nxt          = 1'b1;
          state_nxt            = spa_pkg::S_IDLE;
        end else begin
          rd_en    = 1'b1;
          cmp_nxt  = scan_idx;
          pend_nxt = 1'b1;
          scan_nxt = scan_r + 1'b1;
        end
      end

      default: begin
        state_nxt = spa_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != spa_pkg::S_IDLE);
  assign res_valid = res_vld_r;
  assign res       = res_r;

endmodule

// ===== tb/slot_pool_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// slot_pool_allocator_checker: request predictor and result scoreboard
// Watches the request, result and capacity ports of the slot pool allocator.
// It keeps its own copy of the slot table, predicts one result beat for every
// accepted request and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------

// Request kinds, shared by the checker and the stimulus.
package spa_tb_pkg;

  typedef enum logic {
    KIND_ACQUIRE = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_t;

endpackage

module slot_pool_allocator_checker #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_kind,
  input  logic [spa_pkg::JOB_ID_W-1:0]  in_job_id,
  input  logic                          out_valid,
  input  logic [spa_pkg::STATUS_W-1:0]  out_status,
  input  logic [spa_pkg::SLOT_W-1:0]    out_slot_index,
  input  logic [spa_pkg::COUNT_W-1:0]   out_active_count,
  input  logic                          cfg_we,
  input  logic [spa_pkg::CAP_W-1:0]     cfg_wdata,
  output int                            mismatch_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import spa_pkg::*;
  import spa_tb_pkg::*;

  // Shadow copy of the allocator state and its capacity register.
  logic [31:0]      slot_table [SLOTS];
  int unsigned      occupied;
  logic [CAP_W-1:0] capacity;

  // Predicted result beats, oldest first.
  result_t pending_results [$];
  result_t oldest;

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(string what);
    $display("%0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Applies one request to the shadow table and returns the result it gives.
  function automatic result_t allocate_or_free(logic kind, logic [JOB_ID_W-1:0] job_id);
    logic [63:0] id_mask;
    logic [31:0] id;
    int unsigned usable;
    bit          hit;
    result_t     res;
    id_mask = (64'd1 << ID_BITS) - 64'd1;
    id = 32'(job_id) & id_mask[31:0];
    usable = (capacity > SLOTS) ? SLOTS : capacity;
    hit = 1'b0;
    res.status = ST_OK;
    res.slot_index = '0;
    if (id == 32'd0) begin
      // A zero id is reserved for free slots and never touches the table.
      res.status = ST_ZERO_ID;
    end else if (kind == KIND_ACQUIRE) begin
      // Lowest free slot within the usable range, only while below capacity.
      if (occupied < usable) begin
        for (int i = 0; i < usable; i++) begin
          if (!hit && slot_table[i] == 32'd0) begin
            slot_table[i] = id;
            occupied++;
            res.slot_index = i[SLOT_W-1:0];
            hit = 1'b1;
          end
        end
      end
      if (!hit) res.status = ST_FULL;
    end else begin
      // A release searches every slot, beyond a lowered capacity too.
      for (int i = 0; i < SLOTS; i++) begin
        if (!hit && slot_table[i] == id) begin
          slot_table[i] = 32'd0;
          if (occupied > 0) occupied--;
          res.slot_index = i[SLOT_W-1:0];
          hit = 1'b1;
        end
      end
      if (!hit) res.status = ST_NOT_FOUND;
    end
    res.active_count = occupied[COUNT_W-1:0];
    return res;
  endfunction

  // Result beats are checked before the request of the same edge is predicted,
  // since a beat at that edge always belongs to an earlier request.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (slot_table[i]) slot_table[i] = 32'd0;
      occupied = 0;
      capacity = CAP_RESET;
      pending_results.delete();
      pending_count = 0;
      mismatch_count = 0;
    end else begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding: status %0d",
                                    out_status));
        end else begin
          oldest = pending_results.pop_front();
          if (out_status !== oldest.status)
            report_mismatch($sformatf("status: got %0d, wanted %0d",
                                      out_status, oldest.status));
          if (out_slot_index !== oldest.slot_index)
            report_mismatch($sformatf("slot_index: got %0d, wanted %0d",
                                      out_slot_index, oldest.slot_index));
          if (out_active_count !== oldest.active_count)
            report_mismatch($sformatf("active_count: got %0d, wanted %0d",
                                      out_active_count, oldest.active_count));
        end
      end
      if (cfg_we) capacity = cfg_wdata;
      if (start && !busy) pending_results.push_back(allocate_or_free(in_kind, in_job_id));
      pending_count = pending_results.size();
    end
  end

endmodule

// ===== tb/slot_pool_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// slot_pool_allocator_unit_tb: top level of the slot pool allocator test
// Drives directed and random acquire and release requests in bursts, moves
// the capacity through its extremes while the block is idle, and reports the
// verdict of the checker once every result beat has arrived.
// ----------------------------------------------------------------------------
module slot_pool_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spa_pkg::*;
  import spa_tb_pkg::*;

  localparam int SLOTS        = 16;
  localparam int ID_BITS      = 16;
  localparam int POOL_SIZE    = 20;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 142;
  localparam int DRAIN_CYCLES = SLOTS + 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_kind;
  logic [JOB_ID_W-1:0]  in_job_id;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [SLOT_W-1:0]    out_slot_index;
  logic [COUNT_W-1:0]   out_active_count;
  logic                 cfg_we;
  logic [CAP_W-1:0]     cfg_wdata;
  int                   mismatch_count;
  int                   pending_count;

  logic [JOB_ID_W-1:0]  id_pool [POOL_SIZE];

  slot_pool_allocator_unit #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_job_id        (in_job_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_active_count (out_active_count),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  slot_pool_allocator_checker #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) slot_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_job_id        (in_job_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_active_count (out_active_count),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Presents one request and returns at the edge that accepts it; start stays
  // high so that a following request can go out without a gap.
  task automatic issue(kind_t kind, logic [JOB_ID_W-1:0] job_id);
    start     <= 1'b1;
    in_kind   <= kind;
    in_job_id <= job_id;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Leaves the request port idle for a number of cycles.
  task automatic pause(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Waits until every predicted beat has arrived, then writes the capacity.
  task automatic write_capacity(logic [CAP_W-1:0] value);
    start <= 1'b0;
    do @(negedge clk); while (pending_count != 0 || busy !== 1'b0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly ids from a small pool so that releases hit, some wide random ids
  // that are seldom present, and the odd zero.
  function automatic logic [JOB_ID_W-1:0] pick_job_id();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (roll < 74) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return JOB_ID_W'($urandom);
  endfunction

  // Random requests in bursts; a gapless phase keeps start high throughout.
  task automatic run_phase(int items, int acquire_pct, bit gapless);
    int    burst_left;
    kind_t kind;
    burst_left = $urandom_range(1, 30);
    for (int n = 0; n < items; n++) begin
      kind = ($urandom_range(0, 99) < acquire_pct) ? KIND_ACQUIRE : KIND_RELEASE;
      issue(kind, pick_job_id());
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if (!gapless) pause($urandom_range(1, 12));
      end
    end
  endtask

  // Run timeout.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic [CAP_W-1:0] cap_plan [PHASES];
    int               acquire_mix [4];
    int               waited;

    start     <= 1'b0;
    in_kind   <= KIND_ACQUIRE;
    in_job_id <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= CAP_RESET;
    rst_n     <= 1'b0;

    id_pool[0] = 16'hFFFF;
    id_pool[1] = 16'h0001;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = JOB_ID_W'($urandom_range(1, 65535));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero ids, the widest id, duplicates and a release that misses.
    issue(KIND_ACQUIRE, 16'h0000);
    issue(KIND_RELEASE, 16'h0000);
    issue(KIND_ACQUIRE, 16'hFFFF);
    issue(KIND_ACQUIRE, 16'h0001);
    issue(KIND_ACQUIRE, 16'hFFFF);
    issue(KIND_RELEASE, 16'hFFFF);
    issue(KIND_RELEASE, 16'h1234);
    issue(KIND_ACQUIRE, 16'hAAAA);
    issue(KIND_ACQUIRE, 16'h5555);

    // Capacity lowered below the occupied count; a slot beyond it is freed.
    write_capacity(5'd2);
    issue(KIND_ACQUIRE, 16'h0002);
    issue(KIND_RELEASE, 16'h5555);
    issue(KIND_RELEASE, 16'h0001);
    issue(KIND_ACQUIRE, 16'h0003);
    issue(KIND_RELEASE, 16'hAAAA);
    issue(KIND_ACQUIRE, 16'h0003);

    // A capacity of zero refuses every acquire.
    write_capacity(5'd0);
    issue(KIND_ACQUIRE, 16'h0004);
    issue(KIND_RELEASE, 16'hFFFF);

    // A capacity above the slot count acts as the full table.
    write_capacity(5'd31);
    issue(KIND_ACQUIRE, 16'h8000);
    issue(KIND_RELEASE, 16'h0003);
    issue(KIND_RELEASE, 16'h8000);

    // Random phases over a spread of capacities, extremes among them.
    cap_plan = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd16, 5'd8, 5'd2, 5'd3, 5'd31,
                 5'd16, 5'd12};
    cap_plan[6]  = CAP_W'($urandom_range(1, 16));
    cap_plan[11] = CAP_W'($urandom_range(0, 31));
    acquire_mix  = '{25, 50, 75, 90};
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(cap_plan[p]);
      run_phase(PHASE_ITEMS, (p == 0) ? 85 : acquire_mix[$urandom_range(0, 3)],
                $urandom_range(0, 3) == 0);
    end
    start <= 1'b0;

    // Drain the outstanding beats, with a bound, then let the block settle.
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending_count != 0 && waited < 1000);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
